// ===== hw/rtl/lst_pkg.sv =====
`timescale 1ns / 1ps
package lst_pkg;

    localparam int SPAN_LIMIT_DEF = 64;
    localparam int LINK_LIMIT_DEF = 4096;
    localparam logic [7:0] MASK_RESET = 8'd4;
    localparam logic signed [11:0] ROW_FLOOR = -12'sd2048;

    typedef enum logic [1:0] {
        OP_OPEN   = 2'd0,
        OP_CLOSE  = 2'd1,
        OP_SCROLL = 2'd2,
        OP_POINT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_DROP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [11:0] first_row;
        logic [11:0]        first_col;
        logic signed [11:0] last_row;
        logic [11:0]        last_col;
        logic [11:0]        link;
    } span_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic set_end;
    } cell_ctl_t;

    function automatic logic span_holds(input span_t s, input logic signed [11:0] r,
                                        input logic [11:0] c);
        logic res;
        res = 1'b0;
        if (s.first_row == s.last_row) begin
            res = (r == s.first_row) && (c >= s.first_col) && (c < s.last_col);
        end else if (r >= s.first_row && r <= s.last_row) begin
            if (r == s.first_row) res = (c >= s.first_col);
            else if (r == s.last_row) res = (c < s.last_col);
            else res = 1'b1;
        end
        return res;
    endfunction

    function automatic logic signed [11:0] row_up(input logic signed [11:0] r);
        return (r == ROW_FLOOR) ? ROW_FLOOR : r - 12'sd1;
    endfunction

endpackage

// ===== hw/rtl/lst_cell.sv =====
`timescale 1ns / 1ps
module lst_cell
    import lst_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  span_t     shift_in,
    input  span_t     load_data,
    output span_t     span_q
);

    span_t span_reg;

    // load wins over shift: a kept head lands here during a pass
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            span_reg <= load_data;
        end else if (ctl.set_end) begin
            span_reg.last_row <= load_data.last_row;
            span_reg.last_col <= load_data.last_col;
        end else if (ctl.shift) begin
            span_reg <= shift_in;
        end
    end

    assign span_q = span_reg;

endmodule

// ===== hw/rtl/link_span_table.sv =====
`timescale 1ns / 1ps
// Link span table. Spans sit in a row of cells, oldest in cell 0. Open and close
// go straight to the done state. Scroll and pointer requests rotate every stored
// span once through cell 0 (one span per cycle); an open that overflows the table
// shifts out the oldest half, one per cycle. One request is worked on at a time; a
// finished result waits in the output register while the next request is taken.
module link_span_table
    import lst_pkg::*;
#(
    parameter int SPAN_LIMIT = SPAN_LIMIT_DEF,
    parameter int LINK_LIMIT = LINK_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // link_id[11:0], row[22:12], column[34:23], button[39:35], modifiers[47:40]
    input  logic [47:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit[0], open_request[1], hit_link[13:2], hit_start_row[25:14],
    // hit_start_col[37:26], hit_end_row[49:38], hit_end_col[61:50],
    // entries_held[68:62], zero[71:69]
    output logic [71:0] m_tdata
);

    localparam int DEPTH = SPAN_LIMIT + 1;
    localparam int TW = $clog2(DEPTH + 1);

    span_t     cell_q [DEPTH];
    cell_ctl_t ctl [DEPTH];
    span_t     load_data;

    state_t state_reg, state_next;
    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] rem_reg, rem_next;
    logic [TW-1:0] kept_reg, kept_next;
    logic          open_reg, open_next;
    logic [7:0]    mask_reg;

    op_t              op_reg;
    logic signed [11:0] prow_reg;
    logic [11:0]      pcol_reg;
    logic [4:0]       button_reg;
    logic [7:0]       mods_reg;

    logic  hit_reg, hit_next;
    span_t hspan_reg, hspan_next;

    logic        m_valid_reg;
    logic [71:0] m_data_reg;

    logic [11:0] in_link, in_col;
    logic [10:0] in_row;
    op_t         in_op;
    logic        accept;

    logic          shift_all, do_load, do_end;
    logic [TW-1:0] load_idx, end_idx;
    span_t         head_mod;
    logic          keep;
    logic          want;

    assign in_link = s_tdata[11:0];
    assign in_row  = s_tdata[22:12];
    assign in_col  = s_tdata[34:23];
    assign in_op   = op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept  = s_tvalid && s_tready;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            span_t sin;
            if (gi == DEPTH - 1) begin : g_tail
                assign sin = cell_q[gi];
            end else begin : g_mid
                assign sin = cell_q[gi+1];
            end
            lst_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl[gi]),
                .shift_in (sin),
                .load_data(load_data),
                .span_q   (cell_q[gi])
            );
        end
    endgenerate

    always_comb begin
        head_mod = cell_q[0];
        if (op_reg == OP_SCROLL) begin
            head_mod.first_row = row_up(cell_q[0].first_row);
            head_mod.last_row  = row_up(cell_q[0].last_row);
        end
        keep = (op_reg != OP_SCROLL) || !head_mod.last_row[11];
    end

    assign want = (button_reg == 5'd1) && ((mods_reg & mask_reg) == mask_reg);

    always_comb begin
        state_next = state_reg;
        total_next = total_reg;
        rem_next   = rem_reg;
        kept_next  = kept_reg;
        open_next  = open_reg;
        hit_next   = hit_reg;
        hspan_next = hspan_reg;
        shift_all  = 1'b0;
        do_load    = 1'b0;
        do_end     = 1'b0;
        load_idx   = total_reg;
        end_idx    = total_reg - TW'(1);
        load_data  = '{first_row: $signed({1'b0, in_row}), first_col: in_col,
                       last_row: $signed({1'b0, in_row}), last_col: in_col,
                       link: in_link};
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    hit_next   = 1'b0;
                    hspan_next = '0;
                    rem_next   = total_reg;
                    kept_next  = '0;
                    state_next = ST_DONE;
                    case (in_op) inside
                        OP_OPEN, OP_CLOSE: begin
                            do_end    = open_reg && (total_reg != '0);
                            open_next = 1'b0;
                            if (in_op == OP_OPEN &&
                                {5'd0, in_link} < 17'(LINK_LIMIT)) begin
                                do_load    = 1'b1;
                                open_next  = 1'b1;
                                total_next = total_reg + TW'(1);
                                if (total_next > TW'(SPAN_LIMIT)) begin
                                    rem_next   = total_next >> 1;
                                    state_next = ST_DROP;
                                end
                            end
                        end
                        default: begin
                            if (total_reg != '0) state_next = ST_PASS;
                        end
                    endcase
                end
            end
            ST_PASS: begin
                shift_all = 1'b1;
                load_data = head_mod;
                load_idx  = rem_reg - TW'(1) + kept_reg;
                do_load   = keep;
                if (keep) kept_next = kept_reg + TW'(1);
                if (op_reg == OP_POINT && span_holds(cell_q[0], prow_reg, pcol_reg)) begin
                    hit_next   = 1'b1;
                    hspan_next = cell_q[0];
                end
                rem_next = rem_reg - TW'(1);
                if (rem_reg == TW'(1)) begin
                    total_next = kept_next;
                    state_next = ST_DONE;
                end
            end
            ST_DROP: begin
                shift_all  = 1'b1;
                total_next = total_reg - TW'(1);
                rem_next   = rem_reg - TW'(1);
                if (rem_reg == TW'(1)) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ctl[i].shift   = shift_all;
            ctl[i].load    = do_load && (load_idx == TW'(i));
            ctl[i].set_end = do_end && (end_idx == TW'(i));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            open_reg    <= 1'b0;
            mask_reg    <= MASK_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            open_reg  <= open_next;
            if (cfg_we) mask_reg <= cfg_wdata;
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        kept_reg  <= kept_next;
        hit_reg   <= hit_next;
        hspan_reg <= hspan_next;
        if (accept) begin
            op_reg     <= in_op;
            prow_reg   <= $signed({1'b0, in_row});
            pcol_reg   <= in_col;
            button_reg <= s_tdata[39:35];
            mods_reg   <= s_tdata[47:40];
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {3'd0, 7'(total_reg), hspan_reg.last_col, hspan_reg.last_row,
                           hspan_reg.first_col, hspan_reg.first_row, hspan_reg.link,
                           hit_reg && want, hit_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
